// ----- rtl/peer_table_with_aging_defines.svh -----
// Assertion macros for the peer table top level.
`ifndef PEER_TABLE_WITH_AGING_DEFINES_SVH
`define PEER_TABLE_WITH_AGING_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define PTA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define PTA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pta_pkg.sv -----
// Types and constants shared by the peer table modules.
package pta_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 16;
	localparam logic [31:0] EXPIRY_RESET    = 32'd4000;

	// Register index, taken from paddr[2].
	localparam logic REG_OWN    = 1'b0;
	localparam logic REG_EXPIRY = 1'b1;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_LOST  = 2'd1,
		EV_FOUND = 2'd2,
		EV_FULL  = 2'd3
	} event_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_DOWN,
		CELL_UP
	} cell_op_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] heard;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		logic     wr_en;
	} pta_ctrl_t;

endpackage

// ----- rtl/peer_table_with_aging.sv -----
// Peer table with aging: top level with poll control, config registers and result stage.
//
// One input beat is a poll: s_tdata carries now_ms and sender_address, s_tuser says
// whether a received announcement came with it. The table lives in a row of cells,
// newest peer in cell 0. Once a poll is accepted the row rotates every entry once past
// the age compare at cell 0, one entry per cycle unless an expired head waits for a held
// lost beat to leave the result stage; ST_FINISH then closes the run, and it too can
// stall on m_tready. Expired peers are dropped from the row as they pass and reported as
// lost, newest first; a peer that matches the sender gets its heard time refreshed on
// the way through. An unknown sender (other than own_address) is then pushed in at
// cell 0 and reported as discovered, or reported as dropped when the table is full. A
// poll with no event gives one none beat. m_tlast marks the final beat of each poll.
// Write the config registers (own_address at 0x0, expiry_ms at 0x4) only while no poll
// is in flight.
module peer_table_with_aging #(
	parameter int unsigned TABLE_DEPTH = pta_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] now_ms, [63:32] sender_address
	input  logic        s_tuser,   // [0] mode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] peer_address
	output logic [1:0]  m_tuser,   // [1:0] event_kind
	output logic        m_tlast,   // last_of_run
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

`include "peer_table_with_aging_defines.svh"

	localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// config registers
	logic [31:0] own_q;
	logic [31:0] expiry_q;

	// control state
	pta_pkg::state_t state_q, state_d;
	logic [CW-1:0]   cnt_q;     // peers in the row
	logic [CW-1:0]   step_q;    // entries still to rotate in this sweep
	logic            found_q;
	logic            pend_v_q;
	logic            out_v_q;

	// latched poll
	logic            mode_q;
	logic [31:0]     now_q;
	logic [31:0]     sender_q;

	// one lost event held back until we know whether it closes the run
	logic [31:0]     pend_addr_q;

	// result stage
	pta_pkg::event_kind_t out_kind_q;
	logic [31:0]     out_addr_q;
	logic            out_last_q;

	// chain interface
	pta_pkg::pta_ctrl_t ctrl;
	pta_pkg::entry_t    head;
	pta_pkg::entry_t    bus;
	logic [IDXW-1:0]    wr_ptr;

	// datapath decisions
	logic        accept;
	logic        out_free;
	logic        expired;
	logic        match;
	logic        step_ok;
	logic        fin_ev;
	logic        has_room;
	logic        fin_done;
	logic [31:0] age;

	logic        step;
	logic        pend_ld;
	logic        pend_clr;
	logic        out_ld;
	logic        append;
	pta_pkg::event_kind_t out_kind_d;
	logic [31:0] out_addr_d;
	logic        out_last_d;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_v_q || m_tready;
	assign age      = now_q - head.heard;
	assign expired  = age > expiry_q;
	assign match    = mode_q && (head.addr == sender_q);
	// an expired head with a lost event already pending must push that one out first
	assign step_ok  = !expired || !pend_v_q || out_free;
	assign fin_ev   = mode_q && !found_q && (sender_q != own_q);
	assign has_room = cnt_q < CW'(TABLE_DEPTH);
	assign fin_done = out_free && !(pend_v_q && fin_ev);
	// kept entries go back in at the tail of the live region
	assign wr_ptr   = IDXW'(cnt_q - CW'(1));

	// config port: writes land on the access cycle
	assign pready = 1'b1;
	assign prdata = (paddr[2] == pta_pkg::REG_EXPIRY) ? expiry_q : own_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q    <= '0;
			expiry_q <= pta_pkg::EXPIRY_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == pta_pkg::REG_EXPIRY) begin
				expiry_q <= pwdata;
			end else begin
				own_q <= pwdata;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pta_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (cnt_q == '0) ? pta_pkg::ST_FINISH : pta_pkg::ST_SWEEP;
				end
			end
			pta_pkg::ST_SWEEP: begin
				if (step_ok && step_q == CW'(1)) begin
					state_d = pta_pkg::ST_FINISH;
				end
			end
			pta_pkg::ST_FINISH: begin
				if (fin_done) begin
					state_d = pta_pkg::ST_IDLE;
				end
			end
			default: state_d = pta_pkg::ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		s_tready   = 1'b0;
		ctrl.op    = pta_pkg::CELL_HOLD;
		ctrl.wr_en = 1'b0;
		bus.addr   = head.addr;
		bus.heard  = match ? now_q : head.heard;
		step       = 1'b0;
		pend_ld    = 1'b0;
		pend_clr   = 1'b0;
		out_ld     = 1'b0;
		append     = 1'b0;
		out_kind_d = pta_pkg::EV_LOST;
		out_addr_d = pend_addr_q;
		out_last_d = 1'b0;
		unique case (state_q)
			pta_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			pta_pkg::ST_SWEEP: begin
				if (step_ok) begin
					step       = 1'b1;
					ctrl.op    = pta_pkg::CELL_DOWN;
					ctrl.wr_en = !expired;
					if (expired) begin
						pend_ld = 1'b1;
						out_ld  = pend_v_q;
					end
				end
			end
			pta_pkg::ST_FINISH: begin
				bus.addr  = sender_q;
				bus.heard = now_q;
				if (out_free) begin
					if (pend_v_q) begin
						// pending lost beat closes the run unless a final event follows
						out_ld     = 1'b1;
						pend_clr   = 1'b1;
						out_last_d = !fin_ev;
					end else begin
						out_ld     = 1'b1;
						out_last_d = 1'b1;
						if (fin_ev) begin
							out_addr_d = sender_q;
							if (has_room) begin
								out_kind_d = pta_pkg::EV_FOUND;
								append     = 1'b1;
								ctrl.op    = pta_pkg::CELL_UP;
							end else begin
								out_kind_d = pta_pkg::EV_FULL;
							end
						end else begin
							out_kind_d = pta_pkg::EV_NONE;
							out_addr_d = '0;
						end
					end
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pta_pkg::ST_IDLE;
			cnt_q    <= '0;
			step_q   <= '0;
			found_q  <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q  <= cnt_q;
				found_q <= 1'b0;
			end
			if (step) begin
				step_q <= step_q - CW'(1);
				if (expired) begin
					cnt_q <= cnt_q - CW'(1);
				end else if (match) begin
					found_q <= 1'b1;
				end
			end
			if (append) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (pend_ld) begin
				pend_v_q <= 1'b1;
			end else if (pend_clr) begin
				pend_v_q <= 1'b0;
			end
			if (out_ld) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= s_tuser;
			now_q    <= s_tdata[31:0];
			sender_q <= s_tdata[63:32];
		end
		if (pend_ld) begin
			pend_addr_q <= head.addr;
		end
		if (out_ld) begin
			out_kind_q <= out_kind_d;
			out_addr_q <= out_addr_d;
			out_last_q <= out_last_d;
		end
	end

	pta_chain #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_chain (
		.clk    (clk),
		.ctrl   (ctrl),
		.wr_ptr (wr_ptr),
		.bus    (bus),
		.head   (head)
	);

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_addr_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	`PTA_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CW'(TABLE_DEPTH), "peer count past table depth")
	`PTA_ASSERT_IMPL(a_out_no_overrun, out_ld, out_free, "result beat overwritten before taken")
	`PTA_ASSERT_IMPL(a_accept_clean, accept, !pend_v_q, "poll accepted with lost beat pending")
	`PTA_ASSERT_NEXT(a_sweep_done, state_q == pta_pkg::ST_SWEEP && state_d == pta_pkg::ST_FINISH, step_q == '0, "sweep left entries unvisited")

endmodule

// ----- rtl/pta_cell.sv -----
// One table cell: holds a peer entry, takes a neighbor or the broadcast bus.
module pta_cell (
	input  logic              clk,
	input  pta_pkg::pta_ctrl_t ctrl,
	input  logic              sel,
	input  pta_pkg::entry_t   from_above,
	input  pta_pkg::entry_t   from_below,
	input  pta_pkg::entry_t   bus,
	output pta_pkg::entry_t   q
);

	pta_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && sel) begin
			entry_q <= bus;
		end else begin
			case (ctrl.op)
				pta_pkg::CELL_DOWN: entry_q <= from_above;
				pta_pkg::CELL_UP:   entry_q <= from_below;
				default:            entry_q <= entry_q;
			endcase
		end
	end

	assign q = entry_q;

endmodule

// ----- rtl/pta_chain.sv -----
// Row of table cells; cell 0 is the head that the control examines.
module pta_chain #(
	parameter int unsigned TABLE_DEPTH = pta_pkg::TABLE_DEPTH_DEF,
	localparam int unsigned IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic               clk,
	input  pta_pkg::pta_ctrl_t ctrl,
	input  logic [IDXW-1:0]    wr_ptr,
	input  pta_pkg::entry_t    bus,
	output pta_pkg::entry_t    head
);

	pta_pkg::entry_t q [TABLE_DEPTH];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		pta_pkg::entry_t above;
		pta_pkg::entry_t below;

		if (i == TABLE_DEPTH - 1) begin : g_top
			assign above = bus;
		end else begin : g_mid
			assign above = q[i+1];
		end

		if (i == 0) begin : g_bot
			assign below = bus;
		end else begin : g_up
			assign below = q[i-1];
		end

		pta_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.sel        (wr_ptr == IDXW'(i)),
			.from_above (above),
			.from_below (below),
			.bus        (bus),
			.q          (q[i])
		);
	end

	assign head = q[0];

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for peer_table_with_aging: directed polls, random phases, stalls.
`timescale 1ns / 100ps

module tb;

	localparam int          DEPTH        = pta_pkg::TABLE_DEPTH_DEF;
	localparam int          POOL         = 24;
	localparam int          HOLD_AT      = 45;     // polls accepted before the long hold-off
	localparam int          HOLD_CYCLES  = 400;
	localparam int          LIMIT_CYCLES = 200000;
	localparam int          PRINT_MAX    = 30;
	localparam logic [2:0]  ADDR_OWN     = {pta_pkg::REG_OWN, 2'b00};
	localparam logic [2:0]  ADDR_EXPIRY  = {pta_pkg::REG_EXPIRY, 2'b00};

	// One poll as offered on the input stream.
	typedef struct packed {
		logic        mode;
		logic [31:0] now_ms;
		logic [31:0] sender;
	} poll_t;

	// One table event as seen on the result stream.
	typedef struct packed {
		pta_pkg::event_kind_t kind;
		logic [31:0]          addr;
		logic                 last;
	} peer_event_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;   // [31:0] now_ms, [63:32] sender_address
	logic        s_tuser  = 1'b0; // [0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [31:0] peer_address
	logic [1:0]  m_tuser;         // [1:0] event_kind
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	peer_table_with_aging u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Polls waiting to be offered, and table events still owed by the block.
	poll_t       pending_polls[$];
	peer_event_t owed_events[$];

	// Shadow copy of the table and of the two registers.
	logic [31:0] shadow_addr  [DEPTH];
	logic [31:0] shadow_heard [DEPTH];
	int          shadow_count = 0;
	logic [31:0] cfg_own      = '0;
	logic [31:0] cfg_expiry   = pta_pkg::EXPIRY_RESET;

	logic [31:0] known_addrs [POOL];
	logic [31:0] wall_ms     = '0;

	int  errors        = 0;
	int  cycles        = 0;
	int  polls_in      = 0;
	int  beats_checked = 0;
	int  lost_total    = 0;
	int  full_drops    = 0;
	int  longest_run   = 0;
	bit  quiet         = 1'b0;   // no idling on either side once set
	int  gap_left      = 0;
	int  stall_left    = 0;
	int  hold_left     = 0;
	bit  hold_done     = 1'b0;

	initial forever #6 clk = ~clk;

	// Watchdog: end the run if the block stops making progress.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: watchdog expired after %0d cycles", cycles);
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic report(input string msg);
		if (errors < PRINT_MAX)
			$display("tb: mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// Age the shadow table, then learn the sender; queue the events the poll owes.
	task automatic age_and_learn(input logic mode, input logic [31:0] now,
			input logic [31:0] sender);
		peer_event_t run[$];
		int          slot;
		int          j;
		logic [31:0] age;
		bit          found;

		// Sweep from the newest slot down so removals come out newest first.
		for (slot = shadow_count - 1; slot >= 0; slot--) begin
			age = now - shadow_heard[slot];
			if (age > cfg_expiry) begin
				run.push_back('{kind: pta_pkg::EV_LOST, addr: shadow_addr[slot], last: 1'b0});
				for (j = slot; j + 1 < shadow_count; j++) begin
					shadow_addr[j]  = shadow_addr[j + 1];
					shadow_heard[j] = shadow_heard[j + 1];
				end
				shadow_count--;
				lost_total++;
			end
		end
		if (mode) begin
			found = 1'b0;
			for (slot = 0; slot < shadow_count; slot++) begin
				if (!found && shadow_addr[slot] == sender) begin
					shadow_heard[slot] = now;
					found = 1'b1;
				end
			end
			// Skip our own address unless it is already a stored peer.
			if (!found && sender != cfg_own) begin
				if (shadow_count < DEPTH) begin
					shadow_addr[shadow_count]  = sender;
					shadow_heard[shadow_count] = now;
					shadow_count++;
					run.push_back('{kind: pta_pkg::EV_FOUND, addr: sender, last: 1'b0});
				end else begin
					run.push_back('{kind: pta_pkg::EV_FULL, addr: sender, last: 1'b0});
					full_drops++;
				end
			end
		end
		if (run.size() == 0)
			run.push_back('{kind: pta_pkg::EV_NONE, addr: 32'd0, last: 1'b0});
		run[run.size() - 1].last = 1'b1;
		if (run.size() > longest_run)
			longest_run = run.size();
		foreach (run[k])
			owed_events.push_back(run[k]);
	endtask

	// Driver: offer the next pending poll, with random idle gaps between polls.
	always @(posedge clk or negedge arst_n) begin
		poll_t item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				gap_left <= $urandom_range(0, 3);
				s_tvalid <= 1'b0;
			end else if (pending_polls.size() != 0) begin
				item = pending_polls.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {item.sender, item.now_ms};
				s_tuser  <= item.mode;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stall in random bursts, and once hold off long enough
	// that the block backs up and drops s_tready while polls keep coming.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && polls_in >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: predict on each accepted poll, then check each accepted result beat.
	always @(posedge clk) begin
		peer_event_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				age_and_learn(s_tuser, s_tdata[31:0], s_tdata[63:32]);
				polls_in <= polls_in + 1;
			end
			if (m_tvalid && m_tready) begin
				beats_checked++;
				if (owed_events.size() == 0) begin
					report($sformatf("beat with nothing owed: kind %0d addr %h last %b",
						m_tuser, m_tdata, m_tlast));
				end else begin
					want = owed_events.pop_front();
					if (m_tuser !== want.kind)
						report($sformatf("event kind %0d, want %0d", m_tuser, want.kind));
					if (m_tdata !== want.addr)
						report($sformatf("peer address %h, want %h", m_tdata, want.addr));
					if (m_tlast !== want.last)
						report($sformatf("last flag %b, want %b", m_tlast, want.last));
				end
			end
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_OWN)
			cfg_own = data;
		else if (addr == ADDR_EXPIRY)
			cfg_expiry = data;
	endtask

	task automatic queue_poll(input logic mode, input logic [31:0] now,
			input logic [31:0] sender);
		pending_polls.push_back('{mode: mode, now_ms: now, sender: sender});
	endtask

	// Hold until every poll is out and every owed beat is in, then let the
	// block finish its closing cycles.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_polls.size() != 0 || s_tvalid || owed_events.size() != 0);
		repeat (DEPTH + 8) @(posedge clk);
	endtask

	// Random polls: mostly a small set of recurring peers so entries get
	// refreshed, aged and the table fills; some own-address and wild senders.
	task automatic add_random_polls(input int count, input int step_max);
		int          k;
		int          pick;
		logic [31:0] sender;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 5)
				wall_ms = $urandom();
			else
				wall_ms += $urandom_range(0, step_max);
			pick = $urandom_range(0, 99);
			if (pick < 68)
				sender = known_addrs[$urandom_range(0, POOL - 1)];
			else if (pick < 78)
				sender = cfg_own;
			else
				sender = $urandom();
			queue_poll($urandom_range(0, 9) != 0, wall_ms, sender);
		end
	endtask

	task automatic run_phase(input logic [31:0] own, input logic [31:0] expiry,
			input int count, input int step_max);
		apb_write(ADDR_OWN, own);
		apb_write(ADDR_EXPIRY, expiry);
		@(negedge clk);
		add_random_polls(count, step_max);
		wait_drained();
	endtask

	initial begin
		int k;
		for (k = 0; k < POOL; k++)
			known_addrs[k] = $urandom();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed polls under reset settings (own 0, expiry 4000).
		queue_poll(1'b0, 32'd0, 32'd0);                 // nothing happens
		queue_poll(1'b1, 32'd0, 32'd0);                 // own address as sender: ignored
		queue_poll(1'b1, 32'd100, 32'hFFFF_FFFF);
		queue_poll(1'b1, 32'd200, 32'h0A00_0001);
		queue_poll(1'b1, 32'd4100, 32'hFFFF_FFFF);      // age exactly at the limit: kept
		queue_poll(1'b0, 32'd4201, 32'hFFFF_FFFF);      // one past the limit: lost
		for (k = 0; k < DEPTH - 1; k++)
			queue_poll(1'b1, 32'd5000 + k, 32'hC0A8_0000 | k);
		queue_poll(1'b1, 32'd5020, 32'h5555_AAAA);      // table full: dropped
		queue_poll(1'b1, 32'd9100, 32'hAAAA_5555);      // whole table ages out, then learn
		queue_poll(1'b1, 32'hFFFF_FF00, 32'h1234_5678); // huge age, learn near the wrap
		queue_poll(1'b0, 32'h0000_0100, 32'd0);         // age across the wrap: kept
		wait_drained();

		// Point own_address at a stored peer: it still refreshes and still ages.
		apb_write(ADDR_OWN, (shadow_count != 0) ? shadow_addr[shadow_count - 1] :
			known_addrs[0]);
		@(negedge clk);
		queue_poll(1'b1, 32'h0000_0200, cfg_own);
		queue_poll(1'b0, 32'h0000_0200 + 32'd4001, 32'd0);
		wait_drained();

		// Zero expiry: same-millisecond entries survive, anything older goes.
		apb_write(ADDR_OWN, 32'hFFFF_FFFF);
		apb_write(ADDR_EXPIRY, 32'd0);
		@(negedge clk);
		queue_poll(1'b1, 32'd7000, 32'h0F0F_0F0F);
		queue_poll(1'b0, 32'd7000, 32'd0);
		queue_poll(1'b1, 32'd7001, 32'hFFFF_FFFF);
		wait_drained();

		// Random phases over several settings, extremes included.
		wall_ms = 32'h0000_2000;
		run_phase($urandom(), pta_pkg::EXPIRY_RESET, 45, 900);
		run_phase(32'd0, 32'hFFFF_FFFF, 45, 1000);
		run_phase(known_addrs[3], 32'd0, 35, 2);
		run_phase($urandom(), $urandom_range(300, 3000), 50, 600);
		quiet <= 1'b1;
		run_phase(32'd0, pta_pkg::EXPIRY_RESET, 55, 800);

		$display("tb: %0d polls, %0d result beats checked over eight register settings",
			polls_in, beats_checked);
		$display("tb: %0d peers aged out, %0d dropped on a full table, longest run %0d",
			lost_total, full_drops, longest_run);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
